// File: hw/rtl/mslru_pkg.sv
// Shared codes and field widths for the model slot LRU manager.
`timescale 1ns / 1ps
`default_nettype none
package mslru_pkg;

    localparam int STAMP_W  = 32;
    localparam int TYPE_W   = 3;
    localparam int RECIPE_W = 2;
    localparam int STATUS_W = 4;
    localparam int MAXPT_W  = 5;

    localparam logic [2:0] ACT_LOAD       = 3'd0;
    localparam logic [2:0] ACT_ACCESS     = 3'd1;
    localparam logic [2:0] ACT_UNLOAD     = 3'd2;
    localparam logic [2:0] ACT_UNLOAD_ALL = 3'd3;
    localparam logic [2:0] ACT_QUERY      = 3'd4;

    localparam logic [1:0] RCP_SHARED = 2'd0;
    localparam logic [1:0] RCP_EXCL_A = 2'd1;
    localparam logic [1:0] RCP_EXCL_B = 2'd2;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_MISSING = 2'd1;
    localparam logic [1:0] ERR_INVALID = 2'd2;

    localparam logic [3:0] STS_LOADED     = 4'd0;
    localparam logic [3:0] STS_ALREADY    = 4'd1;
    localparam logic [3:0] STS_ACCESS_OK  = 4'd2;
    localparam logic [3:0] STS_NOT_LOADED = 4'd3;
    localparam logic [3:0] STS_UNLOADED   = 4'd4;
    localparam logic [3:0] STS_MISSING    = 4'd5;
    localparam logic [3:0] STS_INVALID    = 4'd6;
    localparam logic [3:0] STS_RETRY_FAIL = 4'd7;
    localparam logic [3:0] STS_FULL       = 4'd8;
    localparam logic [3:0] STS_RETRIED    = 4'd9;

    localparam logic CFG_LIMIT_ENABLE = 1'b0;

    localparam logic KIND_NOTICE = 1'b0;
    localparam logic KIND_FINAL  = 1'b1;

endpackage
`default_nettype wire

// File: hw/rtl/mslru_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module mslru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/model_slot_lru_manager_core.sv
// Top level of the model slot LRU manager.
// Usage:
//   The s_ channel takes one request per transaction: s_tuser is the action,
//   s_tdata the model key, type, accelerator flag, recipe and load outcome.
//   The m_ channel returns one eviction notice per evicted model, in the
//   order of eviction, and then one final status with m_tlast set.
//   The cfg_ channel writes limit_enable (index 0) and max_per_type (index 1).
// Passes:
//   Slot fields and the eviction list sit in two RAMs with registered reads.
//   Each pass reads every slot of the table in turn. A request runs up
//   to five such passes (lookup, exclusivity, second exclusivity, type limit,
//   full eviction) plus a closing pass for the count and most recent model,
//   with a decision step after each pass; each eviction notice is read from
//   the eviction list RAM and then written to the output register.
//   One request is worked on at a time.
// Reset and stalls:
//   Reset empties the table and clears the use clock; the slot RAM needs no
//   clearing because entries are only used while valid.
//   When the receiver stalls, the block waits with the result held in its
//   output register; the next request is taken while the final status waits.
`timescale 1ns / 1ps
`default_nettype none
module model_slot_lru_manager_core #(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // model_id[15:0], type_code[18:16], on_accel[19], recipe_class[21:20],
    // first_error[23:22], retry_ok[24], zero[31:25]
    input  wire logic [31:0] s_tdata,
    // action[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[3:0], evicted_model[19:4], loaded_count[24:20],
    // recent_model[40:25], recent_valid[41], zero[47:42]
    output logic [47:0]      m_tdata,
    // kind[0]
    output logic [0:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_addr,
    input  wire logic [4:0]  cfg_data
);
    import mslru_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int EXT_W  = (KEY_BITS > 16) ? KEY_BITS : 16;
    localparam int LOW_W  = KEY_BITS + TYPE_W + 1 + RECIPE_W;
    localparam int WORD_W = LOW_W + STAMP_W;
    localparam int CMP_W  = (CNT_W > MAXPT_W) ? CNT_W : MAXPT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_OUTCOME, S_EMIT_RD, S_EMIT_WR, S_FINAL
    } state_t;

    typedef enum logic [2:0] {
        P_FIND, P_EXCL, P_EXCL2, P_LIMIT, P_DROPALL, P_RECENT
    } pass_t;

    state_t                state_reg;
    pass_t                 pass_reg;
    logic                  limit_en_reg;
    logic [MAXPT_W-1:0]    max_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic [STAMP_W-1:0]    use_clock_reg;

    logic [2:0]            act_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [TYPE_W-1:0]     type_reg;
    logic                  accel_reg;
    logic [RECIPE_W-1:0]   recipe_reg;
    logic [1:0]            ferr_reg;
    logic                  rok_reg;
    logic                  retry_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [CNT_W-1:0]      iss_reg;
    logic                  rdv_reg;
    logic [IDX_W-1:0]      rdi_reg;
    logic                  found_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [STAMP_W-1:0]    best_stamp_reg;
    logic [KEY_BITS-1:0]   best_key_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [WORD_W-1:0]     hit_word_reg;
    logic [CNT_W-1:0]      gone_n_reg;
    logic [CNT_W-1:0]      emit_reg;
    logic [CNT_W-1:0]      fin_count_reg;
    logic [15:0]           fin_key_reg;
    logic                  fin_valid_reg;

    logic                  m_valid_reg;
    logic                  m_kind_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [15:0]           m_evicted_reg;
    logic [CNT_W-1:0]      m_count_reg;
    logic [15:0]           m_recent_reg;
    logic                  m_rvalid_reg;
    logic                  m_last_reg;

    // Input unpacking.
    logic [EXT_W-1:0]      id_ext;
    logic [KEY_BITS-1:0]   in_key;
    assign id_ext = EXT_W'(s_tdata[15:0]);
    assign in_key = id_ext[KEY_BITS-1:0];

    // Slot RAM.
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [WORD_W-1:0]     ram_rdata;

    logic [KEY_BITS-1:0]   w_key;
    logic [TYPE_W-1:0]     w_type;
    logic                  w_accel;
    logic [RECIPE_W-1:0]   w_recipe;
    logic [STAMP_W-1:0]    w_stamp;
    logic                  w_v;
    logic                  beat;

    assign w_key    = ram_rdata[KEY_BITS-1:0];
    assign w_type   = ram_rdata[KEY_BITS +: TYPE_W];
    assign w_accel  = ram_rdata[KEY_BITS + TYPE_W];
    assign w_recipe = ram_rdata[KEY_BITS + TYPE_W + 1 +: RECIPE_W];
    assign w_stamp  = ram_rdata[LOW_W +: STAMP_W];
    assign w_v      = valid_reg[rdi_reg];
    assign beat     = (state_reg == S_SCAN) && rdv_reg;

    // Eviction list RAM.
    logic                  gone_we;
    logic [KEY_BITS-1:0]   gone_wdata;
    logic [KEY_BITS-1:0]   gone_rdata;
    logic [IDX_W-1:0]      drop_idx;
    logic                  scan_drop;
    logic                  dec_unload;
    logic                  dec_limit;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      max_ext;

    logic [STAMP_W-1:0]    clk_inc;
    logic                  have_free;
    logic [IDX_W-1:0]      free_idx;
    logic                  touch_we;
    logic                  ins_we;
    logic                  out_free;
    logic                  m_load;
    logic [EXT_W-1:0]      ev_ext;
    logic [EXT_W-1:0]      best_ext;

    assign cnt_ext = CMP_W'(cnt_reg);
    assign max_ext = CMP_W'(max_reg);

    assign scan_drop = beat && w_v && (
        (pass_reg == P_EXCL && w_accel &&
            (recipe_reg != RCP_SHARED || w_recipe == RCP_EXCL_A || w_recipe == RCP_EXCL_B)) ||
        (pass_reg == P_EXCL2 && !found_reg && w_recipe == RCP_SHARED && w_type == type_reg) ||
        (pass_reg == P_DROPALL));
    assign dec_unload = (state_reg == S_DECIDE) && (pass_reg == P_FIND) &&
                        (act_reg == ACT_UNLOAD) && found_reg;
    assign dec_limit  = (state_reg == S_DECIDE) && (pass_reg == P_LIMIT) &&
                        found_reg && (cnt_ext >= max_ext);

    assign gone_we = scan_drop || dec_unload || dec_limit;

    always_comb begin
        if (scan_drop) begin
            gone_wdata = w_key;
            drop_idx   = rdi_reg;
        end else if (dec_unload) begin
            gone_wdata = key_reg;
            drop_idx   = hit_idx_reg;
        end else begin
            gone_wdata = best_key_reg;
            drop_idx   = best_idx_reg;
        end
    end

    assign clk_inc = (&use_clock_reg) ? use_clock_reg : use_clock_reg + 1'b1;

    // Lowest free slot.
    always_comb begin
        have_free = 1'b0;
        free_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                have_free = 1'b1;
                free_idx  = IDX_W'(i);
            end
        end
    end

    assign touch_we = (state_reg == S_DECIDE) && (pass_reg == P_FIND) && found_reg &&
                      (act_reg == ACT_LOAD || act_reg == ACT_ACCESS);
    assign ins_we   = (state_reg == S_OUTCOME) && have_free &&
                      (ferr_reg == ERR_OK || (retry_reg && rok_reg));

    assign ram_we    = touch_we || ins_we;
    assign ram_waddr = touch_we ? hit_idx_reg : free_idx;
    assign ram_wdata = touch_we ? {clk_inc, hit_word_reg[LOW_W-1:0]}
                                : {clk_inc, recipe_reg, accel_reg, type_reg, key_reg};
    assign ram_re    = (state_reg == S_SCAN) && (iss_reg < CNT_W'(SLOTS));

    mslru_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (iss_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    mslru_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_gone_ram (
        .aclk  (aclk),
        .we    (gone_we),
        .waddr (gone_n_reg[IDX_W-1:0]),
        .wdata (gone_wdata),
        .re    (state_reg == S_EMIT_RD),
        .raddr (emit_reg[IDX_W-1:0]),
        .rdata (gone_rdata)
    );

    assign ev_ext   = EXT_W'(gone_rdata);
    assign best_ext = EXT_W'(best_key_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign m_load   = out_free && (state_reg == S_EMIT_WR || state_reg == S_FINAL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pass_reg      <= P_FIND;
            limit_en_reg  <= 1'b0;
            max_reg       <= MAXPT_W'(1);
            valid_reg     <= '0;
            use_clock_reg <= '0;
            m_valid_reg   <= 1'b0;
            rdv_reg       <= 1'b0;
            iss_reg       <= '0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            gone_n_reg    <= '0;
            retry_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_addr == CFG_LIMIT_ENABLE) begin
                    limit_en_reg <= cfg_data[0];
                end else begin
                    max_reg <= cfg_data;
                end
            end
            if (ram_we) begin
                use_clock_reg <= clk_inc;
            end
            if (gone_we) begin
                valid_reg[drop_idx] <= 1'b0;
                gone_n_reg          <= gone_n_reg + 1'b1;
            end
            if (ins_we) begin
                valid_reg[free_idx] <= 1'b1;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg != S_SCAN) begin
                iss_reg <= '0;
                rdv_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        act_reg    <= s_tuser;
                        key_reg    <= in_key;
                        type_reg   <= s_tdata[18:16];
                        accel_reg  <= s_tdata[19];
                        recipe_reg <= s_tdata[21:20];
                        ferr_reg   <= s_tdata[23:22];
                        rok_reg    <= s_tdata[24];
                        gone_n_reg <= '0;
                        found_reg  <= 1'b0;
                        cnt_reg    <= '0;
                        retry_reg  <= 1'b0;
                        state_reg  <= S_SCAN;
                        unique case (s_tuser)
                            ACT_LOAD, ACT_ACCESS, ACT_UNLOAD: pass_reg <= P_FIND;
                            ACT_UNLOAD_ALL: pass_reg <= P_DROPALL;
                            ACT_QUERY: begin
                                status_reg <= (|valid_reg) ? STS_ACCESS_OK : STS_NOT_LOADED;
                                pass_reg   <= P_RECENT;
                            end
                            default: begin
                                status_reg <= STS_NOT_LOADED;
                                pass_reg   <= P_RECENT;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    if (ram_re) begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    rdv_reg <= ram_re;
                    rdi_reg <= iss_reg[IDX_W-1:0];
                    if (beat) begin
                        unique case (pass_reg)
                            P_FIND: begin
                                if (w_v && w_key == key_reg && !found_reg) begin
                                    found_reg    <= 1'b1;
                                    hit_idx_reg  <= rdi_reg;
                                    hit_word_reg <= ram_rdata;
                                end
                            end
                            P_EXCL2: begin
                                if (scan_drop) begin
                                    found_reg <= 1'b1;
                                end
                            end
                            P_LIMIT: begin
                                if (w_v && w_type == type_reg) begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                    if (!found_reg || w_stamp < best_stamp_reg) begin
                                        found_reg      <= 1'b1;
                                        best_stamp_reg <= w_stamp;
                                        best_key_reg   <= w_key;
                                        best_idx_reg   <= rdi_reg;
                                    end
                                end
                            end
                            P_RECENT: begin
                                if (w_v) begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                    if (!found_reg || w_stamp > best_stamp_reg) begin
                                        found_reg      <= 1'b1;
                                        best_stamp_reg <= w_stamp;
                                        best_key_reg   <= w_key;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (rdi_reg == IDX_W'(SLOTS - 1)) begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end

                S_DECIDE: begin
                    // Results of the finished pass are read here and cleared for the next.
                    found_reg <= 1'b0;
                    cnt_reg   <= '0;
                    unique case (pass_reg)
                        P_FIND: begin
                            if (act_reg == ACT_ACCESS) begin
                                status_reg <= found_reg ? STS_ACCESS_OK : STS_NOT_LOADED;
                                pass_reg   <= P_RECENT;
                                state_reg  <= S_SCAN;
                            end else if (act_reg == ACT_UNLOAD) begin
                                status_reg <= found_reg ? STS_UNLOADED : STS_NOT_LOADED;
                                pass_reg   <= P_RECENT;
                                state_reg  <= S_SCAN;
                            end else if (found_reg) begin
                                status_reg <= STS_ALREADY;
                                pass_reg   <= P_RECENT;
                                state_reg  <= S_SCAN;
                            end else if (accel_reg) begin
                                pass_reg  <= P_EXCL;
                                state_reg <= S_SCAN;
                            end else if (limit_en_reg) begin
                                pass_reg  <= P_LIMIT;
                                state_reg <= S_SCAN;
                            end else begin
                                state_reg <= S_OUTCOME;
                            end
                        end
                        P_EXCL: begin
                            if (recipe_reg == RCP_SHARED) begin
                                pass_reg  <= P_EXCL2;
                                state_reg <= S_SCAN;
                            end else if (limit_en_reg) begin
                                pass_reg  <= P_LIMIT;
                                state_reg <= S_SCAN;
                            end else begin
                                state_reg <= S_OUTCOME;
                            end
                        end
                        P_EXCL2: begin
                            if (limit_en_reg) begin
                                pass_reg  <= P_LIMIT;
                                state_reg <= S_SCAN;
                            end else begin
                                state_reg <= S_OUTCOME;
                            end
                        end
                        P_LIMIT: state_reg <= S_OUTCOME;
                        P_DROPALL: begin
                            if (act_reg == ACT_LOAD) begin
                                state_reg <= S_OUTCOME;
                            end else begin
                                status_reg <= STS_UNLOADED;
                                pass_reg   <= P_RECENT;
                                state_reg  <= S_SCAN;
                            end
                        end
                        P_RECENT: begin
                            fin_count_reg <= cnt_reg;
                            fin_valid_reg <= found_reg;
                            fin_key_reg   <= found_reg ? best_ext[15:0] : 16'd0;
                            emit_reg      <= '0;
                            state_reg     <= (gone_n_reg == '0) ? S_FINAL : S_EMIT_RD;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end

                S_OUTCOME: begin
                    found_reg <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= S_SCAN;
                    if (ferr_reg == ERR_OK) begin
                        status_reg <= have_free ? STS_LOADED : STS_FULL;
                        pass_reg   <= P_RECENT;
                    end else if (ferr_reg == ERR_MISSING) begin
                        status_reg <= STS_MISSING;
                        pass_reg   <= P_RECENT;
                    end else if (ferr_reg == ERR_INVALID) begin
                        status_reg <= STS_INVALID;
                        pass_reg   <= P_RECENT;
                    end else if (!retry_reg) begin
                        // Any other failure empties the table before the retry.
                        retry_reg <= 1'b1;
                        pass_reg  <= P_DROPALL;
                    end else if (rok_reg) begin
                        status_reg <= have_free ? STS_RETRIED : STS_FULL;
                        pass_reg   <= P_RECENT;
                    end else begin
                        status_reg <= STS_RETRY_FAIL;
                        pass_reg   <= P_RECENT;
                    end
                end

                S_EMIT_RD: state_reg <= S_EMIT_WR;

                S_EMIT_WR: begin
                    if (out_free) begin
                        m_kind_reg    <= KIND_NOTICE;
                        m_status_reg  <= STS_LOADED;
                        m_evicted_reg <= ev_ext[15:0];
                        m_count_reg   <= fin_count_reg;
                        m_recent_reg  <= fin_key_reg;
                        m_rvalid_reg  <= fin_valid_reg;
                        m_last_reg    <= 1'b0;
                        emit_reg      <= emit_reg + 1'b1;
                        state_reg     <= (emit_reg + 1'b1 == gone_n_reg) ? S_FINAL : S_EMIT_RD;
                    end
                end

                S_FINAL: begin
                    if (out_free) begin
                        m_kind_reg    <= KIND_FINAL;
                        m_status_reg  <= status_reg;
                        m_evicted_reg <= 16'd0;
                        m_count_reg   <= fin_count_reg;
                        m_recent_reg  <= fin_key_reg;
                        m_rvalid_reg  <= fin_valid_reg;
                        m_last_reg    <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_kind_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {6'd0, m_rvalid_reg, m_recent_reg, 5'(m_count_reg),
                        m_evicted_reg, m_status_reg};
endmodule
`default_nettype wire

// File: hw/rtl/mslru_checker.sv
// Port-level assertions for the model slot LRU manager, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mslru_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tlast
);
    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Only the final status closes a request.
    a_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == m_tlast))
        else $error("kind and last disagree");

    // Eviction notices carry no status and the final status names no evicted model.
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast ? (m_tdata[19:4] == 16'd0) : (m_tdata[3:0] == 4'd0)))
        else $error("field not zero where it must be");

    // An empty table reports no count and no recent model.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[41] |-> (m_tdata[24:20] == 5'd0) && (m_tdata[40:25] == 16'd0))
        else $error("empty table reports a model");
endmodule

bind model_slot_lru_manager_core mslru_checker u_mslru_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the model slot LRU manager core.
`timescale 1ns / 1ps
module testbench;
    import mslru_pkg::*;

    localparam int NSLOT = 16;
    localparam logic CFG_MAX_PER_TYPE = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] key;
        logic [2:0]  mtype;
        logic        accel;
        logic [1:0]  recipe;
        logic [1:0]  ferr;
        logic        rok;
    } request_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  status;
        logic [15:0] evicted;
        logic [4:0]  count;
        logic [15:0] recent;
        logic        rvalid;
        logic        last;
    } result_t;

    // Directed row: request plus an optional hand-written final status.
    typedef struct packed {
        request_t   req;
        logic       has_sts;
        logic [3:0] sts;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_addr = 1'b0;
    logic [4:0]  cfg_data = '0;

    model_slot_lru_manager_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state.
    logic        lim_en;
    logic [4:0]  max_pt;
    logic        sv [NSLOT];
    logic [15:0] sm [NSLOT];
    logic [2:0]  st [NSLOT];
    logic        sa [NSLOT];
    logic [1:0]  sr [NSLOT];
    logic [31:0] ss [NSLOT];
    logic [31:0] use_clk;
    logic [15:0] evict_list [$];

    result_t pending_results [$];
    logic [3:0] pinned_status [$];
    row_t plan [$];
    int errors = 0;
    bit quiet = 0;
    int busy_gap = 0;

    task automatic report(input string what, input result_t got, input result_t exp);
        $display("tb: mismatch %s got %h exp %h", what, got, exp);
        errors++;
    endtask

    function automatic void add_row(input request_t r, input logic h, input logic [3:0] v);
        row_t w;
        w.req = r;
        w.has_sts = h;
        w.sts = v;
        plan.insert(plan.size(), w);
    endfunction

    function automatic void touch(input int s);
        if (use_clk != 32'hFFFF_FFFF) use_clk++;
        ss[s] = use_clk;
    endfunction

    function automatic void evict(input int s);
        sv[s] = 1'b0;
        evict_list.insert(evict_list.size(), sm[s]);
    endfunction

    function automatic void evict_all();
        for (int i = 0; i < NSLOT; i++) if (sv[i]) evict(i);
    endfunction

    function automatic int find_key(input logic [15:0] k);
        for (int i = 0; i < NSLOT; i++) if (sv[i] && sm[i] == k) return i;
        return -1;
    endfunction

    function automatic int newest();
        int b;
        b = -1;
        for (int i = 0; i < NSLOT; i++)
            if (sv[i] && (b < 0 || ss[i] > ss[b])) b = i;
        return b;
    endfunction

    function automatic bit place(input request_t r);
        for (int i = 0; i < NSLOT; i++) if (!sv[i]) begin
            sv[i] = 1'b1; sm[i] = r.key; st[i] = r.mtype; sa[i] = r.accel; sr[i] = r.recipe;
            touch(i);
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [3:0] load_outcome(input request_t r);
        int s, lru, cnt;
        s = find_key(r.key);
        if (s >= 0) begin
            touch(s);
            return STS_ALREADY;
        end
        if (r.accel) begin
            if (r.recipe != RCP_SHARED) begin
                for (int i = 0; i < NSLOT; i++) if (sv[i] && sa[i]) evict(i);
            end else begin
                for (int i = 0; i < NSLOT; i++)
                    if (sv[i] && sa[i] && (sr[i] == RCP_EXCL_A || sr[i] == RCP_EXCL_B)) evict(i);
                for (int i = 0; i < NSLOT; i++)
                    if (sv[i] && sr[i] == RCP_SHARED && st[i] == r.mtype) begin
                        evict(i);
                        break;
                    end
            end
        end
        if (lim_en) begin
            lru = -1;
            cnt = 0;
            for (int i = 0; i < NSLOT; i++) if (sv[i] && st[i] == r.mtype) begin
                cnt++;
                if (lru < 0 || ss[i] < ss[lru]) lru = i;
            end
            if (cnt >= max_pt && lru >= 0) evict(lru);
        end
        if (r.ferr == ERR_OK) return place(r) ? STS_LOADED : STS_FULL;
        if (r.ferr == ERR_MISSING) return STS_MISSING;
        if (r.ferr == ERR_INVALID) return STS_INVALID;
        evict_all();
        if (r.rok) return place(r) ? STS_RETRIED : STS_FULL;
        return STS_RETRY_FAIL;
    endfunction

    // Works out the notices and final status that one request causes.
    function automatic void predict_request(input request_t r);
        logic [3:0] sts;
        int s, cnt;
        result_t o;
        evict_list.delete();
        case (r.action)
            ACT_LOAD: sts = load_outcome(r);
            ACT_ACCESS: begin
                s = find_key(r.key);
                if (s >= 0) begin touch(s); sts = STS_ACCESS_OK; end
                else sts = STS_NOT_LOADED;
            end
            ACT_UNLOAD: begin
                s = find_key(r.key);
                if (s >= 0) begin evict(s); sts = STS_UNLOADED; end
                else sts = STS_NOT_LOADED;
            end
            ACT_UNLOAD_ALL: begin evict_all(); sts = STS_UNLOADED; end
            ACT_QUERY: sts = (newest() >= 0) ? STS_ACCESS_OK : STS_NOT_LOADED;
            default: sts = STS_NOT_LOADED;
        endcase
        cnt = 0;
        for (int i = 0; i < NSLOT; i++) if (sv[i]) cnt++;
        s = newest();
        o = '0;
        o.count = cnt[4:0];
        o.recent = (s >= 0) ? sm[s] : 16'd0;
        o.rvalid = (s >= 0);
        foreach (evict_list[i]) begin
            o.kind = KIND_NOTICE; o.evicted = evict_list[i];
            pending_results.insert(pending_results.size(), o);
        end
        o.kind = KIND_FINAL; o.status = sts; o.evicted = '0; o.last = 1'b1;
        pending_results.insert(pending_results.size(), o);
    endfunction

    function automatic request_t rand_request(input bit well);
        request_t r;
        r.action = well ? ((($urandom_range(0, 9)) < 6) ? ACT_LOAD : 3'($urandom_range(1, 4)))
                        : 3'($urandom_range(0, 7));
        // A small key pool makes hits, accesses and unloads land often.
        r.key = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 23)) : 16'($urandom);
        r.mtype = well ? 3'($urandom_range(0, 5)) : 3'($urandom);
        r.accel = 1'($urandom);
        r.recipe = 2'($urandom);
        r.ferr = ($urandom_range(0, 3) < 3) ? ERR_OK : 2'($urandom);
        r.rok = 1'($urandom);
        return r;
    endfunction

    function automatic request_t mk(input logic [2:0] a, input logic [15:0] k,
                                    input logic [2:0] t, input logic ac,
                                    input logic [1:0] rc, input logic [1:0] fe,
                                    input logic ro);
        request_t r;
        r.action = a; r.key = k; r.mtype = t; r.accel = ac; r.recipe = rc;
        r.ferr = fe; r.rok = ro;
        return r;
    endfunction

    task automatic send(input request_t r, input logic has_sts, input logic [3:0] sts);
        int g;
        // Leaves the step of the previous deassertion behind before driving again.
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            g = $urandom_range(1, 16);
            repeat (g) @(negedge aclk);
        end
        predict_request(r);
        pinned_status.insert(pinned_status.size(), has_sts ? sts : 4'hF);
        s_tdata <= {7'd0, r.rok, r.ferr, r.recipe, r.accel, r.mtype, r.key};
        s_tuser <= r.action;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] val);
        drain();
        cfg_addr <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_LIMIT_ENABLE) lim_en = val[0];
        else max_pt = val;
    endtask

    // Receiver: random stall bursts, then compare each transaction.
    initial begin
        result_t got, exp;
        logic [3:0] pin;
        forever begin
            @(negedge aclk);
            if (!quiet && busy_gap > 0) begin
                busy_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                busy_gap = $urandom_range(1, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser[0];
                got.status = m_tdata[3:0];
                got.evicted = m_tdata[19:4];
                got.count = m_tdata[24:20];
                got.recent = m_tdata[40:25];
                got.rvalid = m_tdata[41];
                got.last = m_tlast;
                if (pending_results.size() == 0) begin
                    report("unexpected transaction", got, '0);
                end else begin
                    exp = pending_results.pop_front();
                    if (exp.last) begin
                        pin = pinned_status.pop_front();
                        if (pin != 4'hF && pin != exp.status)
                            report("table status", got, exp);
                    end
                    if (got.kind !== exp.kind) report("kind", got, exp);
                    if (got.status !== exp.status) report("status", got, exp);
                    if (got.evicted !== exp.evicted) report("evicted", got, exp);
                    if (got.count !== exp.count) report("count", got, exp);
                    if (got.recent !== exp.recent) report("recent", got, exp);
                    if (got.rvalid !== exp.rvalid) report("recent_valid", got, exp);
                    if (got.last !== exp.last) report("last", got, exp);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        for (int i = 0; i < NSLOT; i++) sv[i] = 1'b0;
        use_clk = '0;
        lim_en = 1'b0;
        max_pt = 5'd1;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_row(mk(ACT_QUERY, 16'd0, 3'd0, 0, 0, 0, 0), 1'b1, STS_NOT_LOADED);
        add_row(mk(ACT_ACCESS, 16'hFFFF, 3'd7, 1, 3, 3, 1), 1'b1, STS_NOT_LOADED);
        add_row(mk(ACT_UNLOAD, 16'd5, 3'd0, 0, 0, 0, 0), 1'b1, STS_NOT_LOADED);
        add_row(mk(3'd7, 16'hFFFF, 3'd7, 1, 3, 3, 1), 1'b1, STS_NOT_LOADED);
        add_row(mk(3'd5, 16'd1, 3'd1, 0, 1, 1, 0), 1'b1, STS_NOT_LOADED);
        add_row(mk(ACT_LOAD, 16'd0, 3'd0, 0, 0, 0, 0), 1'b1, STS_LOADED);
        add_row(mk(ACT_LOAD, 16'd0, 3'd0, 0, 0, 0, 0), 1'b1, STS_ALREADY);
        add_row(mk(ACT_LOAD, 16'hFFFF, 3'd7, 1, 0, 0, 0), 1'b0, 4'd0);
        add_row(mk(ACT_LOAD, 16'd10, 3'd7, 1, 0, 0, 0), 1'b0, 4'd0);
        add_row(mk(ACT_LOAD, 16'd11, 3'd2, 1, 1, 0, 0), 1'b0, 4'd0);
        add_row(mk(ACT_LOAD, 16'd12, 3'd2, 1, 0, 0, 0), 1'b0, 4'd0);
        add_row(mk(ACT_LOAD, 16'd13, 3'd3, 1, 2, 1, 0), 1'b1, STS_MISSING);
        add_row(mk(ACT_LOAD, 16'd14, 3'd3, 0, 3, 2, 1), 1'b1, STS_INVALID);
        add_row(mk(ACT_LOAD, 16'd15, 3'd4, 1, 3, 0, 0), 1'b0, 4'd0);
        add_row(mk(ACT_ACCESS, 16'd0, 3'd0, 0, 0, 0, 0), 1'b1, STS_ACCESS_OK);
        add_row(mk(ACT_QUERY, 16'd0, 3'd0, 0, 0, 0, 0), 1'b1, STS_ACCESS_OK);
        add_row(mk(ACT_LOAD, 16'd20, 3'd5, 0, 0, 3, 0), 1'b1, STS_RETRY_FAIL);
        add_row(mk(ACT_LOAD, 16'd21, 3'd5, 0, 0, 3, 1), 1'b1, STS_RETRIED);
        add_row(mk(ACT_UNLOAD, 16'd21, 3'd0, 0, 0, 0, 0), 1'b1, STS_UNLOADED);
        for (int i = 0; i < 17; i++)
            add_row(mk(ACT_LOAD, 16'(100 + i), 3'(i % 6), 0, 3, 0, 0), 1'b0, 4'd0);
        add_row(mk(ACT_UNLOAD_ALL, 16'd0, 3'd0, 0, 0, 0, 0), 1'b1, STS_UNLOADED);

        foreach (plan[i]) send(plan[i].req, plan[i].has_sts, plan[i].sts);

        write_reg(CFG_LIMIT_ENABLE, 5'd1);
        write_reg(CFG_MAX_PER_TYPE, 5'd0);
        for (int i = 0; i < 4; i++) send(mk(ACT_LOAD, 16'(200 + i), 3'd1, 0, 0, 0, 0), 0, 0);
        write_reg(CFG_MAX_PER_TYPE, 5'd16);
        for (int i = 0; i < 30; i++) send(rand_request($urandom_range(0, 9) < 8), 0, 0);
        write_reg(CFG_MAX_PER_TYPE, 5'd2);
        for (int i = 0; i < 30; i++) send(rand_request($urandom_range(0, 9) < 8), 0, 0);
        write_reg(CFG_MAX_PER_TYPE, 5'd1);
        for (int i = 0; i < 25; i++) send(rand_request($urandom_range(0, 9) < 8), 0, 0);
        write_reg(CFG_LIMIT_ENABLE, 5'd0);
        write_reg(CFG_MAX_PER_TYPE, 5'($urandom_range(0, 31)));
        for (int i = 0; i < 25; i++) send(rand_request($urandom_range(0, 9) < 8), 0, 0);
        quiet = 1;
        for (int i = 0; i < 20; i++) send(rand_request(1), 0, 0);
        drain();

        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
